// ===== hw/rtl/hfi_pkg.sv =====
`default_nettype none

package hfi_pkg;

   // Width of the wrapping advance counter.
   localparam int unsigned STEP_BITS = 32;

   localparam int unsigned DATA_BITS = 64;
   localparam int unsigned HALF_BITS = DATA_BITS / 2;
   localparam int unsigned CSR_INDEX_BITS = 8;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEED   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PERIOD = CSR_INDEX_BITS'(1);

   // Input op codes.
   localparam logic OP_ADVANCE = 1'b0;
   localparam logic OP_PROBE   = 1'b1;

   // SplitMix64 finalizer constants.
   localparam logic [DATA_BITS-1:0] MIX_GAMMA = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [DATA_BITS-1:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [DATA_BITS-1:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;

   localparam int unsigned MIX_SHIFT_0 = 30;
   localparam int unsigned MIX_SHIFT_1 = 27;
   localparam int unsigned MIX_SHIFT_2 = 31;

   // Status from the hash/modulo engine to the top level.
   typedef struct packed {
      logic idle;
      logic done;
      logic fault;
      logic period_error;
   } hfi_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/hfi_engine.sv =====
`default_nettype none

module hfi_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          take,
   input  wire logic [hfi_pkg::DATA_BITS-1:0] step,
   input  wire logic [hfi_pkg::DATA_BITS-1:0] seed,
   input  wire logic [hfi_pkg::DATA_BITS-1:0] period,
   output      logic [hfi_pkg::DATA_BITS-1:0] step_out,
   output      hfi_pkg::hfi_status_type       status
);
   import hfi_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SUM  = 6'b000010,
      ST_XOR  = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   localparam int unsigned BIT_CNT_BITS = $clog2(DATA_BITS);

   state_type                  state_ff, state_in;
   logic [1:0]                 round_ff, round_in;
   logic [1:0]                 mul_cnt_ff, mul_cnt_in;
   logic [BIT_CNT_BITS-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [DATA_BITS-1:0]       step_ff, step_in;
   logic [DATA_BITS-1:0]       z_ff, z_in;
   logic [DATA_BITS-1:0]       acc_ff, acc_in;
   logic [DATA_BITS-1:0]       prod_ff, prod_in;
   logic [DATA_BITS-1:0]       rem_ff, rem_in;
   logic                       err_ff, err_in;
   logic                       fault_ff, fault_in;

   logic [DATA_BITS-1:0]       mix_const;
   logic [DATA_BITS-1:0]       z_shifted;
   logic [HALF_BITS-1:0]       mul_a;
   logic [HALF_BITS-1:0]       mul_b;
   logic [DATA_BITS-1:0]       mul_prod;
   logic [DATA_BITS:0]         rem_shift;
   logic [DATA_BITS:0]         rem_trial;
   logic [DATA_BITS-1:0]       rem_next;

   // Round 0 uses the first multiplier, round 1 the second.
   assign mix_const = (round_ff == 2'd0) ? MIX_MUL_A : MIX_MUL_B;

   always_comb begin
      unique case (round_ff)
         2'd0:    z_shifted = z_ff >> MIX_SHIFT_0;
         2'd1:    z_shifted = z_ff >> MIX_SHIFT_1;
         default: z_shifted = z_ff >> MIX_SHIFT_2;
      endcase
   end

   // Low 64 bits of z * k from three 32x32 partial products.
   always_comb begin
      unique case (mul_cnt_ff)
         2'd0: begin
            mul_a = z_ff[HALF_BITS-1:0];
            mul_b = mix_const[HALF_BITS-1:0];
         end
         2'd1: begin
            mul_a = z_ff[HALF_BITS-1:0];
            mul_b = mix_const[DATA_BITS-1:HALF_BITS];
         end
         default: begin
            mul_a = z_ff[DATA_BITS-1:HALF_BITS];
            mul_b = mix_const[HALF_BITS-1:0];
         end
      endcase
   end

   // Full 64-bit product of the two 32-bit halves.
   assign mul_prod = {{HALF_BITS{1'b0}}, mul_a} * {{HALF_BITS{1'b0}}, mul_b};

   // One restoring step of the remainder.
   assign rem_shift = {rem_ff, z_ff[DATA_BITS-1]};
   assign rem_trial = rem_shift - {1'b0, period};
   assign rem_next  = rem_trial[DATA_BITS] ? rem_shift[DATA_BITS-1:0]
                                           : rem_trial[DATA_BITS-1:0];

   always_comb begin
      state_in   = state_ff;
      round_in   = round_ff;
      mul_cnt_in = mul_cnt_ff;
      bit_cnt_in = bit_cnt_ff;
      step_in    = step_ff;
      z_in       = z_ff;
      acc_in     = acc_ff;
      prod_in    = prod_ff;
      rem_in     = rem_ff;
      err_in     = err_ff;
      fault_in   = fault_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               step_in  = step;
               err_in   = (period == '0);
               fault_in = 1'b0;
               state_in = (period == '0) ? ST_DONE : ST_SUM;
            end
         end
         ST_SUM: begin
            z_in     = seed + step_ff + MIX_GAMMA;
            round_in = 2'd0;
            state_in = ST_XOR;
         end
         ST_XOR: begin
            z_in = z_ff ^ z_shifted;
            if (round_ff == 2'd2) begin
               rem_in     = '0;
               bit_cnt_in = '0;
               state_in   = ST_DIV;
            end else begin
               mul_cnt_in = 2'd0;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_cnt_ff != 2'd3) begin
               prod_in = mul_prod;
            end
            unique case (mul_cnt_ff)
               2'd0: ;
               2'd1: acc_in = prod_ff;
               2'd2: acc_in = acc_ff + {prod_ff[HALF_BITS-1:0], {HALF_BITS{1'b0}}};
               default: begin
                  z_in     = acc_ff + {prod_ff[HALF_BITS-1:0], {HALF_BITS{1'b0}}};
                  round_in = round_ff + 2'd1;
                  state_in = ST_XOR;
               end
            endcase
            mul_cnt_in = mul_cnt_ff + 2'd1;
         end
         ST_DIV: begin
            rem_in     = rem_next;
            z_in       = z_ff << 1;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_BITS'(1);
            if (bit_cnt_ff == BIT_CNT_BITS'(DATA_BITS - 1)) begin
               fault_in = (rem_next == '0);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      round_ff   <= round_in;
      mul_cnt_ff <= mul_cnt_in;
      bit_cnt_ff <= bit_cnt_in;
      step_ff    <= step_in;
      z_ff       <= z_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      err_ff     <= err_in;
      fault_ff   <= fault_in;
   end

   assign step_out            = step_ff;
   assign status.idle         = (state_ff == ST_IDLE);
   assign status.done         = (state_ff == ST_DONE);
   assign status.fault        = fault_ff;
   assign status.period_error = err_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/hashed_fault_injector.sv =====
// hashed_fault_injector: deterministic SplitMix64-based fault decision.
//
// Channels:
//   csr_*  configuration writes: index 0 = seed, index 1 = period; other
//          indexes are dropped. csr_ready is always high. Write only while
//          the block is idle.
//   req_*  one transaction per test: req_op = advance (bump step counter
//          if period>0, test it) or probe (test req_probe_step, counter held).
//   rsp_*  one transaction per request: fault, period_error, step_tested.
// A request passes the hash/modulo engine's sum step, alternating
// xor-shift and multiply rounds, the bit-serial remainder loop and a
// handoff; a single 32x32 multiplier serves all partial products. A
// zero-period request skips straight to the handoff. req_ready is high
// only while the engine is idle, so a new request is taken only after
// the engine has handed off the last result. Reset clears seed, period
// and the step counter and empties the response register. When the
// receiver stalls the response is held in rsp_*; the engine may take the
// next request meanwhile but holds its result until the register frees up.
`default_nettype none

module hashed_fault_injector (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [hfi_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [hfi_pkg::DATA_BITS-1:0]      csr_wdata,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire logic                               req_op,
   input  wire logic [hfi_pkg::DATA_BITS-1:0]      req_probe_step,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      logic                               rsp_fault,
   output      logic                               rsp_period_error,
   output      logic [hfi_pkg::DATA_BITS-1:0]      rsp_step_tested
);
   import hfi_pkg::*;

   logic [DATA_BITS-1:0]  seed_ff, seed_in;
   logic [DATA_BITS-1:0]  period_ff, period_in;
   logic [STEP_BITS-1:0]  count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_fault_ff;
   logic                  rsp_err_ff;
   logic [DATA_BITS-1:0]  rsp_step_ff;

   logic                  req_take;
   logic                  eng_take;
   logic                  period_zero;
   logic [STEP_BITS-1:0]  count_inc;
   logic [DATA_BITS-1:0]  step_sel;
   logic [DATA_BITS-1:0]  eng_step;
   hfi_status_type        eng_status;

   assign csr_ready = 1'b1;
   assign req_ready = eng_status.idle;
   assign req_take  = req_valid && eng_status.idle;

   // Hand the engine result over once the response register is free.
   assign eng_take  = eng_status.done && (!rsp_valid_ff || rsp_ready);

   assign period_zero = (period_ff == '0);
   assign count_inc   = count_ff + STEP_BITS'(1);

   // Zero period tests nothing: an advance reports the unchanged count.
   always_comb begin
      priority if (req_op == OP_PROBE) begin
         step_sel = req_probe_step;
      end else if (period_zero) begin
         step_sel = DATA_BITS'(count_ff);
      end else begin
         step_sel = DATA_BITS'(count_inc);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (req_take && req_op == OP_ADVANCE && !period_zero) begin
         count_in = count_inc;
      end
   end

   always_comb begin
      seed_in   = seed_ff;
      period_in = period_ff;
      if (csr_valid) begin
         if (csr_index == CSR_SEED) begin
            seed_in = csr_wdata;
         end else if (csr_index == CSR_PERIOD) begin
            period_in = csr_wdata;
         end
      end
   end

   // Load on handoff, drop on acceptance, else hold.
   always_comb begin
      priority if (eng_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   hfi_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (req_take),
      .take     (eng_take),
      .step     (step_sel),
      .seed     (seed_ff),
      .period   (period_ff),
      .step_out (eng_step),
      .status   (eng_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         period_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         period_ff    <= period_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_take) begin
         rsp_fault_ff <= eng_status.fault;
         rsp_err_ff   <= eng_status.period_error;
         rsp_step_ff  <= eng_step;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fault        = rsp_fault_ff;
   assign rsp_period_error = rsp_err_ff;
   assign rsp_step_tested  = rsp_step_ff;

endmodule

`default_nettype wire
